@@ rtl/rhh_pkg.sv @@
// Shared types for the Robin Hood hash table: controller states, datapath
// commands, result codes and the datapath status bundle.
// No dependencies.
package rhh_pkg;

    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_LK_INIT,
        S_LK_RD,
        S_LK_EV,
        S_INS_RD,
        S_INS_EV,
        S_RM_RD,
        S_RM_EV,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV,
        CMD_LK_INIT,
        CMD_READ,
        CMD_LK_NEXT,
        CMD_PUT_REPL,
        CMD_INS_INIT,
        CMD_INS_EMPTY,
        CMD_INS_STEP,
        CMD_RM_INIT,
        CMD_RM_READ,
        CMD_RM_STEP,
        CMD_RM_END,
        CMD_CLR_INIT,
        CMD_CLR
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       div_last;
        logic       clr_last;
        logic       hit;
        logic       empty;
        logic       stop_lookup;
        logic       shift_stop;
        logic       bound;
        logic       full;
    } dp_stat_t;

endpackage

@@ rtl/rhh_datapath.sv @@
// Datapath of the Robin Hood hash table: slot memory, home-slot remainder
// unit, probe counters, carried entry and slot count.
// Depends on rhh_pkg.
module rhh_datapath #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rhh_pkg::cmd_t    cmd,
    input  logic             cfg_wr,
    input  logic [10:0]      cfg_data,
    input  logic [1:0]       in_mode,
    input  logic [31:0]      in_hash,
    input  logic [31:0]      in_key,
    input  logic [31:0]      in_value,
    output logic [31:0]      slots_rd,
    output rhh_pkg::dp_stat_t stat
);
    import rhh_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int HW = SW + 1;
    localparam int WW = HW + KEY_BITS + VALUE_BITS;
    localparam int SLOTS_RST = (SLOTS < 1024) ? SLOTS : 1024;

    logic [WW-1:0]         mem [SLOTS];
    logic [WW-1:0]         rd_word_reg;

    logic [HW-1:0]         slots_reg;
    logic [HW-1:0]         count_reg, count_next;
    logic [1:0]            mode_reg;
    logic [31:0]           hash_reg;
    logic [SW-1:0]         rem_reg;
    logic [4:0]            div_cnt_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SW-1:0]         i_reg;
    logic [HW-1:0]         j_reg;
    logic [HW-1:0]         n_reg;
    logic [WW-1:0]         carry_reg;
    logic [SW-1:0]         clr_reg;

    logic [HW-1:0]         rd_home;
    logic [KEY_BITS-1:0]   rd_key;
    logic [SW-1:0]         rd_home0;
    logic [SW-1:0]         next_i;
    logic [HW-1:0]         dist_i;
    logic [HW-1:0]         dist_ni;
    logic [SW:0]           trial;
    logic [SW-1:0]         rd_addr;
    logic                  we;
    logic [SW-1:0]         wa;
    logic [WW-1:0]         wd;
    logic [31:0]           cfg_v;

    assign rd_home  = rd_word_reg[WW-1 -: HW];
    assign rd_key   = rd_word_reg[VALUE_BITS +: KEY_BITS];
    assign rd_home0 = SW'(rd_home - HW'(1));

    assign next_i  = ((HW'(i_reg) + HW'(1)) >= slots_reg) ? '0 : SW'(i_reg + SW'(1));

    assign dist_i  = (i_reg >= rd_home0) ? HW'(i_reg - rd_home0)
                                         : HW'(HW'(i_reg) + slots_reg - HW'(rd_home0));
    assign dist_ni = (next_i >= rd_home0) ? HW'(next_i - rd_home0)
                                          : HW'(HW'(next_i) + slots_reg - HW'(rd_home0));

    assign trial = {rem_reg, hash_reg[31]};

    assign stat.mode        = mode_reg;
    assign stat.div_last    = (div_cnt_reg == 5'd31);
    assign stat.clr_last    = (32'(clr_reg) == 32'(SLOTS - 1));
    assign stat.empty       = (rd_home == '0);
    assign stat.hit         = (rd_home != '0) && (rd_key == key_reg);
    assign stat.stop_lookup = (j_reg > dist_i);
    assign stat.shift_stop  = (rd_home == '0) || (dist_ni == '0);
    assign stat.bound       = ((n_reg + HW'(1)) >= slots_reg);
    assign stat.full        = (count_reg >= slots_reg);

    assign slots_rd = 32'(slots_reg);

    always_comb
    begin
        cfg_v = 32'(cfg_data);
        if (cfg_v == 32'd0)
        begin
            cfg_v = 32'd1;
        end
        if (cfg_v > 32'(SLOTS))
        begin
            cfg_v = 32'(SLOTS);
        end
    end

    always_comb
    begin
        rd_addr = (cmd == CMD_RM_READ) ? next_i : i_reg;
        we      = 1'b0;
        wa      = i_reg;
        wd      = '0;
        case (cmd)
            CMD_PUT_REPL:
            begin
                we = 1'b1;
                wd = {rd_home, rd_key, value_reg};
            end
            CMD_INS_EMPTY:
            begin
                we = 1'b1;
                wd = carry_reg;
            end
            CMD_INS_STEP:
            begin
                we = (j_reg >= dist_i);
                wd = carry_reg;
            end
            CMD_RM_STEP:
            begin
                we = 1'b1;
                wd = rd_word_reg;
            end
            CMD_RM_END:
            begin
                we = 1'b1;
            end
            CMD_CLR:
            begin
                we = 1'b1;
                wa = clr_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_comb
    begin
        count_next = count_reg;
        case (cmd)
            CMD_INS_EMPTY: count_next = count_reg + HW'(1);
            CMD_RM_END:    count_next = (count_reg != '0) ? count_reg - HW'(1) : count_reg;
            CMD_CLR_INIT:  count_next = '0;
            default:       count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg   <= HW'(SLOTS_RST);
            count_reg   <= '0;
            clr_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                slots_reg <= HW'(cfg_v);
            end
            count_reg <= count_next;
            case (cmd)
                CMD_CLR_INIT: clr_reg <= '0;
                CMD_CLR:      clr_reg <= SW'(clr_reg + SW'(1));
                CMD_LOAD:     div_cnt_reg <= '0;
                CMD_DIV:      div_cnt_reg <= div_cnt_reg + 5'd1;
                default:      clr_reg <= clr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                mode_reg  <= in_mode;
                hash_reg  <= in_hash;
                key_reg   <= KEY_BITS'(in_key);
                value_reg <= VALUE_BITS'(in_value);
                rem_reg   <= '0;
            end
            CMD_DIV:
            begin
                hash_reg <= {hash_reg[30:0], 1'b0};
                if (HW'(trial) >= slots_reg)
                begin
                    rem_reg <= SW'(HW'(trial) - slots_reg);
                end
                else
                begin
                    rem_reg <= SW'(trial);
                end
            end
            CMD_LK_INIT:
            begin
                i_reg <= rem_reg;
                j_reg <= '0;
                n_reg <= '0;
            end
            CMD_LK_NEXT:
            begin
                i_reg <= next_i;
                j_reg <= j_reg + HW'(1);
                n_reg <= n_reg + HW'(1);
            end
            CMD_INS_INIT:
            begin
                i_reg     <= rem_reg;
                j_reg     <= '0;
                n_reg     <= '0;
                carry_reg <= {HW'(rem_reg) + HW'(1), key_reg, value_reg};
            end
            CMD_INS_STEP:
            begin
                if (j_reg >= dist_i)
                begin
                    carry_reg <= rd_word_reg;
                    j_reg     <= dist_i + HW'(1);
                end
                else
                begin
                    j_reg <= j_reg + HW'(1);
                end
                i_reg <= next_i;
                n_reg <= n_reg + HW'(1);
            end
            CMD_RM_INIT:
            begin
                n_reg <= '0;
            end
            CMD_RM_STEP:
            begin
                i_reg <= next_i;
                n_reg <= n_reg + HW'(1);
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

endmodule

@@ rtl/rhh_controller.sv @@
// Sequencer of the Robin Hood hash table: clearing pass, remainder steps,
// lookup, insert and backward-shift probes, and the result register.
// Depends on rhh_pkg.
module rhh_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_status,
    input  rhh_pkg::dp_stat_t stat,
    output rhh_pkg::cmd_t     cmd
);
    import rhh_pkg::*;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    status_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    assign in_ready   = (state_reg == S_IDLE) && !cfg_wr;
    assign out_valid  = out_valid_reg;
    assign out_status = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
            res_reg       <= ST_INSERTED;
            out_reg       <= ST_INSERTED;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = CMD_NONE;
        if (cfg_wr)
        begin
            cmd        = CMD_CLR_INIT;
            state_next = S_CLR;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    cmd = CMD_CLR;
                    if (stat.clr_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd        = CMD_LOAD;
                        state_next = S_DIV;
                    end
                end
                S_DIV:
                begin
                    cmd = CMD_DIV;
                    if (stat.div_last)
                    begin
                        state_next = S_LK_INIT;
                    end
                end
                S_LK_INIT:
                begin
                    cmd        = CMD_LK_INIT;
                    state_next = S_LK_RD;
                end
                S_LK_RD:
                begin
                    cmd        = CMD_READ;
                    state_next = S_LK_EV;
                end
                S_LK_EV:
                begin
                    if (stat.hit && !stat.stop_lookup)
                    begin
                        if (stat.mode == MODE_PUT)
                        begin
                            cmd        = CMD_PUT_REPL;
                            res_next   = ST_REPLACED;
                            state_next = S_DONE;
                        end
                        else if (stat.mode == MODE_REMOVE)
                        begin
                            cmd        = CMD_RM_INIT;
                            state_next = S_RM_RD;
                        end
                        else
                        begin
                            res_next   = ST_FOUND;
                            state_next = S_DONE;
                        end
                    end
                    else if (stat.empty || stat.stop_lookup || stat.bound)
                    begin
                        state_next = S_DONE;
                        if (stat.mode == MODE_PUT)
                        begin
                            if (stat.full)
                            begin
                                res_next = ST_FULL;
                            end
                            else
                            begin
                                cmd        = CMD_INS_INIT;
                                state_next = S_INS_RD;
                            end
                        end
                        else
                        begin
                            res_next = ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        cmd        = CMD_LK_NEXT;
                        state_next = S_LK_RD;
                    end
                end
                S_INS_RD:
                begin
                    cmd        = CMD_READ;
                    state_next = S_INS_EV;
                end
                S_INS_EV:
                begin
                    if (stat.empty)
                    begin
                        cmd        = CMD_INS_EMPTY;
                        res_next   = ST_INSERTED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd = CMD_INS_STEP;
                        if (stat.bound)
                        begin
                            res_next   = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                end
                S_RM_RD:
                begin
                    cmd        = CMD_RM_READ;
                    state_next = S_RM_EV;
                end
                S_RM_EV:
                begin
                    if (stat.shift_stop || stat.bound)
                    begin
                        cmd        = CMD_RM_END;
                        res_next   = ST_REMOVED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd        = CMD_RM_STEP;
                        state_next = S_RM_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_next       = res_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_CLR;
                end
            endcase
        end
    end

endmodule

@@ rtl/robin_hood_hash_table.sv @@
// Robin Hood hash table with linear probing and backward-shift deletion.
// Each operation runs remainder steps and setup, then a read state and an evaluate
// state per probed, displaced or shifted slot (one memory port), then the output register.
// One transaction in flight; a result may wait in the output register, and
// s_tready rises the cycle after the result is loaded. Reset or a register write
// starts a clearing pass over all SLOTS slots; s_tready is low meanwhile.
module robin_hood_hash_table #(
    parameter int SLOTS      = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // hash_value[31:0], key[63:32], value[95:64]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status[2:0], zero[7:3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rhh_pkg::*;

    cmd_t       cmd;
    dp_stat_t   stat;
    logic       cfg_wr;
    logic [2:0] status;
    logic [31:0] slots_rd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && !paddr[2];
    assign prdata  = paddr[2] ? 32'd0 : slots_rd;
    assign m_tdata = {5'd0, status};

    rhh_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .stat       (stat),
        .cmd        (cmd)
    );

    rhh_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_wr   (cfg_wr),
        .cfg_data (pwdata[10:0]),
        .in_mode  (s_tuser),
        .in_hash  (s_tdata[31:0]),
        .in_key   (s_tdata[63:32]),
        .in_value (s_tdata[95:64]),
        .slots_rd (slots_rd),
        .stat     (stat)
    );

endmodule

@@ verif/tb_robin_hood_hash_table.sv @@
// Self-checking testbench for robin_hood_hash_table: directed table, then random
// put/get/remove traffic checked against an in-bench Robin Hood table predictor.
// Depends on rtl/rhh_pkg.sv and rtl/robin_hood_hash_table.sv.
module tb_robin_hood_hash_table;
    timeunit 1ns;
    timeprecision 1ps;
    import rhh_pkg::*;

    localparam int SLOTS = 1024;
    localparam int POOL = 64;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  mode;
        logic [31:0] hash;
        logic [31:0] key;
        logic [31:0] value;
        bit          chk;
        status_t     st;
    } req_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // hash_value[31:0], key[63:32], value[95:64]
    logic [1:0]  s_tuser = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // status[2:0], zero[7:3]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned tbl_home [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    logic [31:0] tbl_value [SLOTS];
    int unsigned entry_count;
    int unsigned slots_used;

    status_t     status_q [$];
    int unsigned err_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic [31:0] pool_key [POOL];
    logic [31:0] pool_hash [POOL];

    robin_hood_hash_table DUT (.*);

    always #2 clk = ~clk;

    function automatic int unsigned probe_dist(int unsigned i, int unsigned home);
        return (i >= home) ? i - home : i + slots_used - home;
    endfunction

    function automatic int unsigned step_slot(int unsigned i);
        return (i + 1 >= slots_used) ? 0 : i + 1;
    endfunction

    function automatic bit find_key(int unsigned home, logic [31:0] key,
                                    output int unsigned pos);
        int unsigned i;
        int unsigned h;
        i = home;
        pos = 0;
        for (int unsigned j = 0; j < slots_used; j++)
        begin
            h = tbl_home[i];
            if (h == 0 || j > probe_dist(i, h - 1))
                return 1'b0;
            if (tbl_key[i] == key)
            begin
                pos = i;
                return 1'b1;
            end
            i = step_slot(i);
        end
        return 1'b0;
    endfunction

    function automatic status_t table_put(int unsigned home, logic [31:0] key,
                                          logic [31:0] value);
        int unsigned pos;
        int unsigned c_home;
        logic [31:0] c_key;
        logic [31:0] c_val;
        int unsigned i;
        int unsigned j;
        int unsigned p;
        int unsigned th;
        logic [31:0] tk;
        logic [31:0] tv;
        c_home = home + 1;
        c_key = key;
        c_val = value;
        i = home;
        j = 0;
        if (find_key(home, key, pos))
        begin
            tbl_value[pos] = value;
            return ST_REPLACED;
        end
        if (entry_count >= slots_used)
            return ST_FULL;
        for (int unsigned n = 0; n < slots_used; n++)
        begin
            if (tbl_home[i] == 0)
            begin
                tbl_home[i] = c_home;
                tbl_key[i] = c_key;
                tbl_value[i] = c_val;
                entry_count++;
                return ST_INSERTED;
            end
            p = probe_dist(i, tbl_home[i] - 1);
            if (j >= p)
            begin
                th = tbl_home[i];
                tk = tbl_key[i];
                tv = tbl_value[i];
                tbl_home[i] = c_home;
                tbl_key[i] = c_key;
                tbl_value[i] = c_val;
                c_home = th;
                c_key = tk;
                c_val = tv;
                j = p;
            end
            i = step_slot(i);
            j++;
        end
        return ST_FULL;
    endfunction

    function automatic status_t table_remove(int unsigned home, logic [31:0] key);
        int unsigned i;
        int unsigned ni;
        int unsigned nh;
        if (!find_key(home, key, i))
            return ST_NOT_FOUND;
        tbl_home[i] = 0;
        for (int unsigned n = 0; n < slots_used; n++)
        begin
            ni = step_slot(i);
            nh = tbl_home[ni];
            if (nh == 0 || probe_dist(ni, nh - 1) == 0)
                break;
            tbl_home[i] = nh;
            tbl_key[i] = tbl_key[ni];
            tbl_value[i] = tbl_value[ni];
            tbl_home[ni] = 0;
            i = ni;
        end
        if (entry_count > 0)
            entry_count--;
        return ST_REMOVED;
    endfunction

    function automatic status_t table_op(logic [1:0] mode, logic [31:0] hash,
                                         logic [31:0] key, logic [31:0] value);
        int unsigned home;
        int unsigned pos;
        home = hash % slots_used;
        if (mode == MODE_PUT)
            return table_put(home, key, value);
        if (mode == MODE_REMOVE)
            return table_remove(home, key);
        return find_key(home, key, pos) ? ST_FOUND : ST_NOT_FOUND;
    endfunction

    function automatic void table_resize(logic [31:0] wval);
        int unsigned v;
        v = wval & 32'h7FF;
        if (v == 0)
            v = 1;
        if (v > SLOTS)
            v = SLOTS;
        slots_used = v;
        entry_count = 0;
        for (int k = 0; k < SLOTS; k++)
            tbl_home[k] = 0;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_slots(logic [31:0] wval);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= wval;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        table_resize(wval);
    endtask

    task automatic send_req(logic [1:0] mode, logic [31:0] hash, logic [31:0] key,
                            logic [31:0] value, bit chk, status_t st);
        status_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {value, key, hash};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = table_op(mode, hash, key, value);
        status_q.push_back(chk ? st : predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual status %0d",
                         $time, m_tdata);
                err_count++;
            end
            else if (m_tdata !== {5'b0, status_q[0]})
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, status_q[0], m_tdata);
                err_count++;
                void'(status_q.pop_front());
            end
            else
                void'(status_q.pop_front());
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        req_row_t dir_rows [] = '{
            '{0, MODE_GET,    32'd0,        32'd5,        32'd0,        1, ST_NOT_FOUND},
            '{0, MODE_REMOVE, 32'd0,        32'd5,        32'd0,        1, ST_NOT_FOUND},
            '{0, MODE_PUT,    32'd7,        32'h11,       32'hAAAA,     1, ST_INSERTED},
            '{0, MODE_PUT,    32'd7,        32'h11,       32'h5555,     1, ST_REPLACED},
            '{0, 2'd3,        32'd7,        32'h11,       32'd0,        1, ST_FOUND},
            '{0, MODE_PUT,    32'd7,        32'h22,       32'd1,        1, ST_INSERTED},
            '{0, MODE_PUT,    32'd8,        32'h33,       32'd2,        0, ST_INSERTED},
            '{0, MODE_REMOVE, 32'd7,        32'h11,       32'd0,        1, ST_REMOVED},
            '{0, MODE_GET,    32'd7,        32'h22,       32'd0,        1, ST_FOUND},
            '{0, MODE_GET,    32'd8,        32'h33,       32'd0,        1, ST_FOUND},
            '{0, MODE_PUT,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, ST_INSERTED},
            '{0, MODE_PUT,    32'd0,        32'd0,        32'd0,        1, ST_INSERTED},
            '{0, MODE_GET,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,        1, ST_FOUND},
            '{0, MODE_REMOVE, 32'd0,        32'd0,        32'd0,        1, ST_REMOVED},
            '{1, MODE_PUT,    32'd0,        32'd0,        32'd0,        0, ST_INSERTED},
            '{0, MODE_PUT,    32'd5,        32'd1,        32'd3,        1, ST_INSERTED},
            '{0, MODE_PUT,    32'd9,        32'd2,        32'd4,        1, ST_FULL},
            '{0, MODE_PUT,    32'd9,        32'd1,        32'd6,        1, ST_REPLACED},
            '{0, MODE_REMOVE, 32'd3,        32'd1,        32'd0,        1, ST_REMOVED},
            '{1, MODE_PUT,    32'd0,        32'd0,        32'h7FF,      0, ST_INSERTED}
        };
        int unsigned seg_slots [7] = '{1024, 3, 2, 16, 64, 2047, 1024};
        int unsigned pick;
        int unsigned roll;
        int unsigned psize;
        logic [1:0]  mode;
        logic [31:0] hash;
        logic [31:0] key;

        table_resize(32'd1024);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 8;
        rx_idle_pct = 79;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
                write_slots(dir_rows[r].value);
            else
                send_req(dir_rows[r].mode, dir_rows[r].hash, dir_rows[r].key,
                         dir_rows[r].value, dir_rows[r].chk, dir_rows[r].st);
        end

        for (int seg = 0; seg < 7; seg++)
        begin
            tx_idle_pct = (seg < 3) ? 8 : (seg < 5) ? 79 : 0;
            rx_idle_pct = (seg < 3) ? 79 : (seg < 5) ? 8 : 0;
            write_slots(seg_slots[seg]);
            psize = (slots_used + 4 < POOL) ? slots_used + 4 : POOL;
            for (int k = 0; k < POOL; k++)
            begin
                pool_key[k] = $urandom();
                pool_hash[k] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 63);
            end
            for (int n = 0; n < 160; n++)
            begin
                if (n == 80)
                    wait_drained();
                pick = $urandom_range(0, psize - 1);
                hash = pool_hash[pick];
                key = pool_key[pick];
                if ($urandom_range(0, 9) == 0)
                begin
                    hash = $urandom();
                    key = $urandom();
                end
                roll = $urandom_range(0, 99);
                mode = (roll < 45) ? MODE_PUT : (roll < 75) ? MODE_GET :
                       (roll < 95) ? MODE_REMOVE : 2'd3;
                send_req(mode, hash, key, $urandom(), 0, ST_INSERTED);
            end
        end

        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/rhh_pkg.sv
rtl/rhh_datapath.sv
rtl/rhh_controller.sv
rtl/robin_hood_hash_table.sv
verif/tb_robin_hood_hash_table.sv
